/* rtl/arri_pkg.sv */
// shared types and constants for the ray against rectangle intersection unit
package arri_pkg;

  localparam int COORD_W = 32;
  localparam int FRAC_W = 16;
  localparam int UV_W = FRAC_W + 1;
  localparam int PT_W = COORD_W + FRAC_W + 1;
  localparam int DIV_NUM_W = COORD_W + FRAC_W + 1;
  localparam int DIV_DEN_W = COORD_W + 1;
  localparam int DIV_STAGES = DIV_NUM_W;
  localparam int T_W = DIV_NUM_W + 1;
  localparam int EPS_Q = ((1 << FRAC_W) + 5000) / 10000;
  localparam int ADDR_W = 5;

  localparam logic [1:0] AXIS_XY = 2'd0;
  localparam logic [1:0] AXIS_YZ = 2'd1;
  localparam logic [1:0] AXIS_XZ = 2'd2;

  localparam logic [ADDR_W-1:0] REG_PLANE_AXIS = 5'd0;
  localparam logic [ADDR_W-1:0] REG_PLANE_OFFSET = 5'd4;
  localparam logic [ADDR_W-1:0] REG_FIRST_LOW = 5'd8;
  localparam logic [ADDR_W-1:0] REG_FIRST_HIGH = 5'd12;
  localparam logic [ADDR_W-1:0] REG_SECOND_LOW = 5'd16;
  localparam logic [ADDR_W-1:0] REG_SECOND_HIGH = 5'd20;

  typedef struct packed {
    logic signed [COORD_W-1:0] max_distance;
    logic signed [COORD_W-1:0] min_distance;
    logic signed [COORD_W-1:0] dir_z;
    logic signed [COORD_W-1:0] dir_y;
    logic signed [COORD_W-1:0] dir_x;
    logic signed [COORD_W-1:0] org_z;
    logic signed [COORD_W-1:0] org_y;
    logic signed [COORD_W-1:0] org_x;
  } ray_t;

  typedef struct packed {
    logic valid;
    logic bad;
    logic neg;
    logic front;
    ray_t ray;
  } div1_side_t;

  typedef struct packed {
    logic valid;
    logic hit;
    logic front;
    logic signed [COORD_W-1:0] t;
    ray_t ray;
  } hit_side_t;

  typedef struct packed {
    logic valid;
    logic hit;
    logic front;
    logic signed [COORD_W-1:0] t;
    logic signed [PT_W-1:0] p_x;
    logic signed [PT_W-1:0] p_y;
    logic signed [PT_W-1:0] p_z;
  } pt_side_t;

  typedef struct packed {
    logic u_zero;
    logic v_zero;
    pt_side_t pt;
  } div2_side_t;

endpackage

/* rtl/arri_div.sv */
// pipelined unsigned restoring divider, one quotient bit per stage
module arri_div (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic [arri_pkg::DIV_NUM_W-1:0]        num,
  input  logic [arri_pkg::DIV_DEN_W-1:0]        den,
  output logic [arri_pkg::DIV_NUM_W-1:0]        quo
);

  localparam int N = arri_pkg::DIV_NUM_W;
  localparam int D = arri_pkg::DIV_DEN_W;
  localparam int S = arri_pkg::DIV_STAGES;

  logic [D:0]   rem  [S];
  logic [N-1:0] numr [S];
  logic [D-1:0] denr [S];
  logic [N-1:0] quor [S];

  for (genvar s = 0; s < S; s++) begin : g_stage
    logic [D:0]   rem_src;
    logic [N-1:0] num_src;
    logic [D-1:0] den_src;
    logic [N-1:0] quo_src;
    logic [D:0]   trial;
    logic         ge;

    if (s == 0) begin : g_first
      assign rem_src = '0;
      assign num_src = num;
      assign den_src = den;
      assign quo_src = '0;
    end else begin : g_next
      assign rem_src = rem[s-1];
      assign num_src = numr[s-1];
      assign den_src = denr[s-1];
      assign quo_src = quor[s-1];
    end

    assign trial = {rem_src[D-1:0], num_src[N-1]};
    assign ge = trial >= {1'b0, den_src};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s]  <= ge ? trial - {1'b0, den_src} : trial;
        numr[s] <= {num_src[N-2:0], 1'b0};
        denr[s] <= den_src;
        quor[s] <= {quo_src[N-2:0], ge};
      end
    end
  end

  assign quo = quor[S-1];

endmodule

/* rtl/axis_rect_ray_intersect.sv */
// ray against axis-aligned rectangle intersection unit, top level
//
// Takes one ray per cycle unless the output stalls, and gives one result per
// ray, in order. Two pipelined restoring dividers of 49 stages each (the plane
// distance, then u and v side by side) make up most of the pipeline, with a
// register stage for the input, the window test, the direction products, the
// hit point, and the output. A stall on the output side holds the whole
// pipeline; the output register keeps the finished item meanwhile.
module axis_rect_ray_intersect (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // org_x, org_y, org_z, dir_x, dir_y, dir_z, min_distance, max_distance
  input  logic [8*arri_pkg::COORD_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // hit_distance, tex_u, tex_v, point_x, point_y, point_z, front_face, pad
  output logic [167:0]                       m_axis_tdata,
  // hit_flag
  output logic                               m_axis_tuser,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [arri_pkg::ADDR_W-1:0]        paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);

  localparam int CW = arri_pkg::COORD_W;
  localparam int FW = arri_pkg::FRAC_W;
  localparam int PW = arri_pkg::PT_W;
  localparam int TW = arri_pkg::T_W;
  localparam int NW = arri_pkg::DIV_NUM_W;
  localparam int DW = arri_pkg::DIV_DEN_W;
  localparam int S = arri_pkg::DIV_STAGES;

  // configuration
  logic [1:0]           plane_axis;
  logic signed [CW-1:0] plane_offset, first_low, first_high, second_low, second_high;
  logic                 wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_axis  <= arri_pkg::AXIS_XY;
      plane_offset <= '0;
      first_low   <= '0;
      first_high  <= CW'(1 << FW);
      second_low  <= '0;
      second_high <= CW'(1 << FW);
    end else if (wr) begin
      unique case (paddr)
        arri_pkg::REG_PLANE_AXIS:   plane_axis <= pwdata[1:0];
        arri_pkg::REG_PLANE_OFFSET: plane_offset <= pwdata;
        arri_pkg::REG_FIRST_LOW:    first_low <= pwdata;
        arri_pkg::REG_FIRST_HIGH:   first_high <= pwdata;
        arri_pkg::REG_SECOND_LOW:   second_low <= pwdata;
        arri_pkg::REG_SECOND_HIGH:  second_high <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      arri_pkg::REG_PLANE_AXIS:   prdata = {30'd0, plane_axis};
      arri_pkg::REG_PLANE_OFFSET: prdata = plane_offset;
      arri_pkg::REG_FIRST_LOW:    prdata = first_low;
      arri_pkg::REG_FIRST_HIGH:   prdata = first_high;
      arri_pkg::REG_SECOND_LOW:   prdata = second_low;
      arri_pkg::REG_SECOND_HIGH:  prdata = second_high;
      default:                    prdata = '0;
    endcase
  end

  // pipeline advance
  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // input stage
  logic           a_valid;
  arri_pkg::ray_t a_ray;

  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else if (en) a_valid <= s_axis_tvalid;
  end
  always_ff @(posedge clk) begin
    if (en) a_ray <= s_axis_tdata;
  end

  // distance numerator and divisor
  logic signed [CW-1:0] a_on, a_dn;
  logic                 a_axis_ok;
  logic signed [CW:0]   a_diff;
  logic signed [NW-1:0] a_num_s;
  logic [NW-1:0]        a_num;
  logic signed [DW-1:0] a_den_s;
  logic [DW-1:0]        a_den;
  arri_pkg::div1_side_t a_side;

  always_comb begin
    a_axis_ok = 1'b1;
    unique case (plane_axis)
      arri_pkg::AXIS_XY: begin a_on = a_ray.org_z; a_dn = a_ray.dir_z; end
      arri_pkg::AXIS_YZ: begin a_on = a_ray.org_x; a_dn = a_ray.dir_x; end
      arri_pkg::AXIS_XZ: begin a_on = a_ray.org_y; a_dn = a_ray.dir_y; end
      default: begin a_on = '0; a_dn = '0; a_axis_ok = 1'b0; end
    endcase
    a_diff = {plane_offset[CW-1], plane_offset} - {a_on[CW-1], a_on};
    a_num_s = {a_diff, {FW{1'b0}}};
    a_num = a_num_s[NW-1] ? NW'(-a_num_s) : NW'(a_num_s);
    a_den_s = {a_dn[CW-1], a_dn};
    a_den = a_dn[CW-1] ? DW'(-a_den_s) : DW'(a_den_s);
    a_side.valid = a_valid;
    a_side.bad = !a_axis_ok || (a_dn == '0);
    a_side.neg = a_diff[CW] ^ a_dn[CW-1];
    a_side.front = a_dn[CW-1];
    a_side.ray = a_ray;
  end

  logic [NW-1:0]        t_quo;
  arri_pkg::div1_side_t s1 [S];

  arri_div u_div_t (.clk(clk), .en(en), .num(a_num), .den(a_den), .quo(t_quo));

  for (genvar s = 0; s < S; s++) begin : g_side1
    always_ff @(posedge clk) begin
      if (rst) s1[s].valid <= 1'b0;
      else if (en) s1[s] <= (s == 0) ? a_side : s1[(s == 0) ? 0 : s-1];
    end
  end

  // window test
  logic signed [TW-1:0] b_t;
  logic                 b_in;
  arri_pkg::div1_side_t b_s;
  arri_pkg::hit_side_t  c_s;

  always_comb begin
    b_s = s1[S-1];
    b_t = b_s.neg ? -$signed({1'b0, t_quo}) : $signed({1'b0, t_quo});
    b_in = !b_s.bad && (b_t >= TW'(b_s.ray.min_distance))
           && (b_t <= TW'(b_s.ray.max_distance));
  end

  always_ff @(posedge clk) begin
    if (rst) c_s.valid <= 1'b0;
    else if (en) begin
      c_s.valid <= b_s.valid;
      c_s.hit <= b_in;
      c_s.front <= b_s.front;
      c_s.t <= b_t[CW-1:0];
      c_s.ray <= b_s.ray;
    end
  end

  // direction products
  arri_pkg::hit_side_t    d_s;
  logic signed [2*CW-1:0] d_px, d_py, d_pz;

  always_ff @(posedge clk) begin
    if (rst) d_s.valid <= 1'b0;
    else if (en) begin
      d_s <= c_s;
      d_px <= c_s.t * c_s.ray.dir_x;
      d_py <= c_s.t * c_s.ray.dir_y;
      d_pz <= c_s.t * c_s.ray.dir_z;
    end
  end

  // hit point
  arri_pkg::pt_side_t e_s;
  logic signed [2*CW-1:0] d_fx, d_fy, d_fz;

  assign d_fx = d_px >>> FW;
  assign d_fy = d_py >>> FW;
  assign d_fz = d_pz >>> FW;

  always_ff @(posedge clk) begin
    if (rst) e_s.valid <= 1'b0;
    else if (en) begin
      e_s.valid <= d_s.valid;
      e_s.hit <= d_s.hit;
      e_s.front <= d_s.front;
      e_s.t <= d_s.t;
      e_s.p_x <= PW'(d_s.ray.org_x) + d_fx[PW-1:0];
      e_s.p_y <= PW'(d_s.ray.org_y) + d_fy[PW-1:0];
      e_s.p_z <= PW'(d_s.ray.org_z) + d_fz[PW-1:0];
    end
  end

  // bounds test and texture numerators
  logic signed [PW-1:0] f_p1, f_p2, f_r1, f_r2;
  logic                 f_inside;
  logic [NW-1:0]        f_unum, f_vnum;
  logic [DW-1:0]        f_uden, f_vden;
  arri_pkg::div2_side_t f_side;

  always_comb begin
    unique case (plane_axis)
      arri_pkg::AXIS_YZ: begin f_p1 = e_s.p_y; f_p2 = e_s.p_z; end
      arri_pkg::AXIS_XZ: begin f_p1 = e_s.p_x; f_p2 = e_s.p_z; end
      default:           begin f_p1 = e_s.p_x; f_p2 = e_s.p_y; end
    endcase
    f_inside = (f_p1 >= PW'(first_low)) && (f_p1 <= PW'(first_high))
               && (f_p2 >= PW'(second_low)) && (f_p2 <= PW'(second_high));
    f_r1 = f_p1 - PW'(first_low);
    f_r2 = f_p2 - PW'(second_low);
    f_unum = {f_r1[DW-1:0], {FW{1'b0}}};
    f_vnum = {f_r2[DW-1:0], {FW{1'b0}}};
    f_uden = DW'({first_high[CW-1], first_high} - {first_low[CW-1], first_low});
    f_vden = DW'({second_high[CW-1], second_high} - {second_low[CW-1], second_low});
    f_side.u_zero = first_high == first_low;
    f_side.v_zero = second_high == second_low;
    f_side.pt = e_s;
    f_side.pt.hit = e_s.hit && f_inside;
  end

  logic [NW-1:0]        u_quo, v_quo;
  arri_pkg::div2_side_t s2 [S];

  arri_div u_div_u (.clk(clk), .en(en), .num(f_unum), .den(f_uden), .quo(u_quo));
  arri_div u_div_v (.clk(clk), .en(en), .num(f_vnum), .den(f_vden), .quo(v_quo));

  for (genvar s = 0; s < S; s++) begin : g_side2
    always_ff @(posedge clk) begin
      if (rst) s2[s].pt.valid <= 1'b0;
      else if (en) s2[s] <= (s == 0) ? f_side : s2[(s == 0) ? 0 : s-1];
    end
  end

  // result assembly
  arri_pkg::div2_side_t g_s;
  logic signed [PW-1:0] g_px, g_py, g_pz;
  logic signed [PW-1:0] g_eps;
  logic [CW-1:0]        g_sx, g_sy, g_sz;
  logic [arri_pkg::UV_W-1:0] g_u, g_v;
  logic                 g_hit;

  function automatic logic [CW-1:0] sat_coord(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] hi, lo;
    hi = PW'({1'b0, {(CW-1){1'b1}}});
    lo = -hi - PW'(1);
    if (v > hi) return hi[CW-1:0];
    if (v < lo) return lo[CW-1:0];
    return v[CW-1:0];
  endfunction

  always_comb begin
    g_s = s2[S-1];
    g_hit = g_s.pt.hit;
    g_eps = g_s.pt.front ? PW'(arri_pkg::EPS_Q) : -PW'(arri_pkg::EPS_Q);
    g_px = g_s.pt.p_x;
    g_py = g_s.pt.p_y;
    g_pz = g_s.pt.p_z;
    unique case (plane_axis)
      arri_pkg::AXIS_YZ: g_px = g_s.pt.p_x + g_eps;
      arri_pkg::AXIS_XZ: g_py = g_s.pt.p_y + g_eps;
      default:           g_pz = g_s.pt.p_z + g_eps;
    endcase
    g_sx = sat_coord(g_px);
    g_sy = sat_coord(g_py);
    g_sz = sat_coord(g_pz);
    g_u = g_s.u_zero ? '0 : u_quo[arri_pkg::UV_W-1:0];
    g_v = g_s.v_zero ? '0 : v_quo[arri_pkg::UV_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) m_axis_tvalid <= 1'b0;
    else if (en) m_axis_tvalid <= g_s.pt.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tuser <= g_hit;
      if (g_hit)
        m_axis_tdata <= {5'd0, g_s.pt.front, g_sz, g_sy, g_sx, g_v, g_u, g_s.pt.t};
      else
        m_axis_tdata <= '0;
    end
  end

  a_rst_idle: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("miss item carries data");
  a_uv_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[48:32] <= 17'h10000
      && m_axis_tdata[65:49] <= 17'h10000)
    else $error("texture coordinate out of range");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    en && g_s.pt.valid |=> m_axis_tvalid)
    else $error("item lost at output");

endmodule
